// ===== rtl/core/cpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcs_pkg
// Shared constants and types of the circle pair collision sweep core.
// ----------------------------------------------------------------------------
package cpcs_pkg;

   localparam int MAX_BODIES = 16;
   localparam int IDX_W      = $clog2(MAX_BODIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int RESULT_CAP = MAX_BODIES - 1;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = 15;
   localparam int ITER_W     = 5;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic rd;
      logic load;
      logic sq;
      logic sum;
      logic zero;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic mul;
      logic fin;
      logic commit;
      logic flush;
      logic store;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             skip;
      logic             hit;
      logic             zero;
      logic             out_free;
      logic             held_v;
   } status_type;

   typedef struct packed {
      logic [31:0]        first_entity;
      logic [31:0]        second_entity;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic [22:0]        depth;
      logic signed [23:0] contact_x;
      logic signed [23:0] contact_y;
   } result_type;

endpackage

// ===== rtl/core/cpcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpcs_ctrl
// Sequencer: walks the stored bodies and steps the datapath per pair.
// ----------------------------------------------------------------------------
module cpcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cpcs_pkg::status_type  st,
   output cpcs_pkg::cmd_type     cmd,
   output logic [cpcs_pkg::IDX_W-1:0] rd_idx
);
   import cpcs_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_NEXT   = 15'b000000000000010,
      S_READ   = 15'b000000000000100,
      S_LOAD   = 15'b000000000001000,
      S_SQ     = 15'b000000000010000,
      S_SUM    = 15'b000000000100000,
      S_TEST   = 15'b000000001000000,
      S_SQRT   = 15'b000000010000000,
      S_DIVI   = 15'b000000100000000,
      S_DIV    = 15'b000001000000000,
      S_MUL    = 15'b000010000000000,
      S_FIN    = 15'b000100000000000,
      S_COMMIT = 15'b001000000000000,
      S_FLUSH  = 15'b010000000000000,
      S_STORE  = 15'b100000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  rc_ff, rc_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rd_idx    = idx_ff[IDX_W-1:0];

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rc_in    = rc_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               idx_in     = '0;
               rc_in      = '0;
               state_in   = S_NEXT;
            end
         end
         S_NEXT: begin
            if (idx_ff < st.count && rc_ff < CNT_W'(RESULT_CAP)) state_in = S_READ;
            else state_in = S_FLUSH;
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            if (st.skip) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_NEXT;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            priority if (!st.hit) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_NEXT;
            end else if (st.zero) begin
               cmd.zero = 1'b1;
               state_in = S_MUL;
            end else begin
               cmd.sqrt_init = 1'b1;
               iter_in       = '0;
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SQRT_STEPS - 1)) state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            iter_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_STEPS - 1)) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!st.held_v || st.out_free) begin
               cmd.commit = 1'b1;
               rc_in      = rc_ff + 1'b1;
               idx_in     = idx_ff + 1'b1;
               state_in   = S_NEXT;
            end
         end
         S_FLUSH: begin
            if (!st.held_v) begin
               state_in = S_STORE;
            end else if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         rc_ff    <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         rc_ff    <= rc_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// ===== rtl/core/cpcs_datapath.sv =====
// ----------------------------------------------------------------------------
// cpcs_datapath
// Body store, pair arithmetic, bit-serial square root and dividers, result
// holding and output registers.
// ----------------------------------------------------------------------------
module cpcs_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  cpcs_pkg::cmd_type           cmd,
   input  logic [cpcs_pkg::IDX_W-1:0]  rd_idx,
   output cpcs_pkg::status_type        st,
   input  logic                        req_start_frame,
   input  logic [31:0]                 req_entity_id,
   input  logic signed [23:0]          req_pos_x,
   input  logic signed [23:0]          req_pos_y,
   input  logic [21:0]                 req_radius,
   input  logic                        req_is_ability,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cpcs_pkg::result_type        rsp_res,
   output logic                        rsp_last
);
   import cpcs_pkg::*;

   // body store
   logic [31:0]        mem_id [MAX_BODIES];
   logic signed [23:0] mem_x  [MAX_BODIES];
   logic signed [23:0] mem_y  [MAX_BODIES];
   logic [21:0]        mem_r  [MAX_BODIES];
   logic               mem_ab [MAX_BODIES];
   logic [31:0]        mq_id_ff;
   logic signed [23:0] mq_x_ff, mq_y_ff;
   logic [21:0]        mq_r_ff;
   logic               mq_ab_ff;
   logic [CNT_W-1:0]   count_ff;

   // new body
   logic [31:0]        nid_ff;
   logic signed [23:0] nx_ff, ny_ff;
   logic [21:0]        nr_ff;
   logic               nab_ff;

   // pair stages
   logic [31:0]        fid_ff, sid_ff;
   logic signed [24:0] dx_ff, dy_ff;
   logic signed [23:0] sx_ff, sy_ff;
   logic [21:0]        sr_ff;
   logic [22:0]        rs_ff;
   logic [23:0]        ax_ff, ay_ff;
   logic               sgx_ff, sgy_ff;
   logic [47:0]        dx2_ff, dy2_ff;
   logic [45:0]        rs2_ff;
   logic [48:0]        l2_ff;

   // square root and dividers
   logic [61:0]        sv_ff, res_ff, bit_ff;
   logic [46:0]        remx_ff, remy_ff;
   logic [44:0]        dv_ff;
   logic [14:0]        qx_ff, qy_ff;
   logic [36:0]        pmx_ff, pmy_ff;

   result_type         new_ff, held_ff, out_ff;
   logic               held_v_ff, out_v_ff, out_last_ff;

   logic               new_first;
   logic [62:0]        trial;
   logic [30:0]        s_val;
   logic               out_free;

   function automatic logic signed [23:0] contact(input logic signed [23:0] base,
                                                  input logic neg,
                                                  input logic [36:0] p);
      logic [22:0]        m;
      logic signed [25:0] v;
      begin
         m = 23'((p + 37'd8192) >> 14);
         v = neg ? 26'(base) - 26'(m) : 26'(base) + 26'(m);
         if (v > 26'sd8388607) contact = 24'sh7FFFFF;
         else if (v < -26'sd8388608) contact = 24'sh800000;
         else contact = v[23:0];
      end
   endfunction

   function automatic logic signed [15:0] norm(input logic neg, input logic [14:0] q);
      logic [15:0] c;
      begin
         c    = (q > 15'd16384) ? 16'd16384 : {1'b0, q};
         norm = neg ? -c : c;
      end
   endfunction

   assign new_first    = nid_ff < mq_id_ff;
   assign trial        = {1'b0, res_ff} + {1'b0, bit_ff};
   assign s_val        = res_ff[30:0];
   assign out_free     = !out_v_ff || !rsp_stall;

   assign st.count    = count_ff;
   assign st.skip     = (mq_id_ff == nid_ff) || (nab_ff && mq_ab_ff);
   assign st.hit      = l2_ff < {3'b0, rs2_ff};
   assign st.zero     = (l2_ff == '0);
   assign st.out_free = out_free;
   assign st.held_v   = held_v_ff;

   assign rsp_valid = out_v_ff;
   assign rsp_res   = out_ff;
   assign rsp_last  = out_last_ff;

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.store && count_ff < CNT_W'(MAX_BODIES)) begin
         mem_id[count_ff[IDX_W-1:0]] <= nid_ff;
         mem_x[count_ff[IDX_W-1:0]]  <= nx_ff;
         mem_y[count_ff[IDX_W-1:0]]  <= ny_ff;
         mem_r[count_ff[IDX_W-1:0]]  <= nr_ff;
         mem_ab[count_ff[IDX_W-1:0]] <= nab_ff;
      end
      if (cmd.rd) begin
         mq_id_ff <= mem_id[rd_idx];
         mq_x_ff  <= mem_x[rd_idx];
         mq_y_ff  <= mem_y[rd_idx];
         mq_r_ff  <= mem_r[rd_idx];
         mq_ab_ff <= mem_ab[rd_idx];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.accept && req_start_frame) begin
         count_ff <= '0;
      end else if (cmd.store && count_ff < CNT_W'(MAX_BODIES)) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // pair arithmetic
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         nid_ff <= req_entity_id;
         nx_ff  <= req_pos_x;
         ny_ff  <= req_pos_y;
         nr_ff  <= req_radius;
         nab_ff <= req_is_ability;
      end
      if (cmd.load) begin
         fid_ff <= new_first ? nid_ff : mq_id_ff;
         sid_ff <= new_first ? mq_id_ff : nid_ff;
         dx_ff  <= new_first ? 25'(nx_ff) - 25'(mq_x_ff) : 25'(mq_x_ff) - 25'(nx_ff);
         dy_ff  <= new_first ? 25'(ny_ff) - 25'(mq_y_ff) : 25'(mq_y_ff) - 25'(ny_ff);
         sx_ff  <= new_first ? mq_x_ff : nx_ff;
         sy_ff  <= new_first ? mq_y_ff : ny_ff;
         sr_ff  <= new_first ? mq_r_ff : nr_ff;
         rs_ff  <= 23'(nr_ff) + 23'(mq_r_ff);
      end
      if (cmd.sq) begin
         ax_ff  <= dx_ff[24] ? 24'(-dx_ff) : dx_ff[23:0];
         ay_ff  <= dy_ff[24] ? 24'(-dy_ff) : dy_ff[23:0];
         sgx_ff <= dx_ff[24];
         sgy_ff <= dy_ff[24];
         dx2_ff <= 48'(dx_ff * dx_ff);
         dy2_ff <= 48'(dy_ff * dy_ff);
         rs2_ff <= rs_ff * rs_ff;
      end
      if (cmd.sum) l2_ff <= 49'(dx2_ff) + 49'(dy2_ff);
      // square root, one result bit per step
      if (cmd.zero) begin
         res_ff <= '0;
      end else if (cmd.sqrt_init) begin
         sv_ff  <= {l2_ff[45:0], 16'd0};
         res_ff <= '0;
         bit_ff <= 62'd1 << 60;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, sv_ff} >= trial) begin
            sv_ff  <= sv_ff - trial[61:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      // restoring dividers for both normal components
      if (cmd.zero) begin
         qx_ff <= '0;
         qy_ff <= '0;
      end else if (cmd.div_init) begin
         remx_ff <= {1'b0, ax_ff, 22'd0} + 47'(s_val >> 1);
         remy_ff <= {1'b0, ay_ff, 22'd0} + 47'(s_val >> 1);
         dv_ff   <= {s_val, 14'd0};
         qx_ff   <= '0;
         qy_ff   <= '0;
      end else if (cmd.div_step) begin
         if (remx_ff >= 47'(dv_ff)) begin
            remx_ff <= remx_ff - 47'(dv_ff);
            qx_ff   <= {qx_ff[13:0], 1'b1};
         end else begin
            qx_ff   <= {qx_ff[13:0], 1'b0};
         end
         if (remy_ff >= 47'(dv_ff)) begin
            remy_ff <= remy_ff - 47'(dv_ff);
            qy_ff   <= {qy_ff[13:0], 1'b1};
         end else begin
            qy_ff   <= {qy_ff[13:0], 1'b0};
         end
         dv_ff <= dv_ff >> 1;
      end
      if (cmd.mul) begin
         pmx_ff <= 37'(qx_ff) * 37'(sr_ff);
         pmy_ff <= 37'(qy_ff) * 37'(sr_ff);
      end
      if (cmd.fin) begin
         new_ff.first_entity  <= fid_ff;
         new_ff.second_entity <= sid_ff;
         new_ff.normal_x      <= norm(sgx_ff, qx_ff);
         new_ff.normal_y      <= norm(sgy_ff, qy_ff);
         new_ff.depth         <= rs_ff - 23'(s_val >> 8);
         new_ff.contact_x     <= contact(sx_ff, sgx_ff, pmx_ff);
         new_ff.contact_y     <= contact(sy_ff, sgy_ff, pmy_ff);
      end
      if (cmd.commit) held_ff <= new_ff;
      if ((cmd.commit && held_v_ff) || cmd.flush) out_ff <= held_ff;
   end

   // holding slot and output register; last is known once the next hit or
   // the end of the sweep is seen
   always_ff @(posedge clock) begin
      if (reset) begin
         held_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         if (cmd.commit) held_v_ff <= 1'b1;
         else if (cmd.flush) held_v_ff <= 1'b0;
         if ((cmd.commit && held_v_ff) || cmd.flush) begin
            out_v_ff    <= 1'b1;
            out_last_ff <= cmd.flush;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/circle_pair_collision_sweep_core.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collision_sweep_core
// Tests each incoming circle against the stored circles of the frame.
// ----------------------------------------------------------------------------
// One body is taken at a time. For each stored body the core reads the
// store and loads the pair, skipping it on a matching id or when both are
// abilities; otherwise it squares the offsets, sums them and tests for
// overlap. Each overlapping pair then runs a 31-step bit-serial square root,
// a divider setup step and 15-step dividers for the normal, then product,
// rounding and commit; a hit with coincident centers goes straight to the
// product. A stalled result holds the sweep. Results of a body come out in
// store order, the last one flagged. start_frame empties the store; bodies
// beyond 16 are tested but not kept.
module circle_pair_collision_sweep_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_frame,
   input  logic [31:0]        req_entity_id,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic [21:0]        req_radius,
   input  logic               req_is_ability,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_first_entity,
   output logic [31:0]        rsp_second_entity,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [22:0]        rsp_depth,
   output logic signed [23:0] rsp_contact_x,
   output logic signed [23:0] rsp_contact_y,
   output logic               rsp_last
);
   import cpcs_pkg::*;

   cmd_type          cmd;
   status_type       st;
   logic [IDX_W-1:0] rd_idx;
   result_type       res;

   cpcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd),
      .rd_idx    (rd_idx)
   );

   cpcs_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_idx          (rd_idx),
      .st              (st),
      .req_start_frame (req_start_frame),
      .req_entity_id   (req_entity_id),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_radius      (req_radius),
      .req_is_ability  (req_is_ability),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_res         (res),
      .rsp_last        (rsp_last)
   );

   // unpack the result record
   assign rsp_first_entity  = res.first_entity;
   assign rsp_second_entity = res.second_entity;
   assign rsp_normal_x      = res.normal_x;
   assign rsp_normal_y      = res.normal_y;
   assign rsp_depth         = res.depth;
   assign rsp_contact_x     = res.contact_x;
   assign rsp_contact_y     = res.contact_y;

endmodule
